FILE: hdl/pixel_color_effect_assert.svh
// Assertion macros for the pixel color effect block.
`ifndef PIXEL_COLOR_EFFECT_ASSERT_SVH
`define PIXEL_COLOR_EFFECT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PCE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("pixel_color_effect: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("pixel_color_effect: next-cycle check failed");

`endif

FILE: hdl/pce_pkg.sv
// Shared types, constants and arithmetic helpers for the pixel color effect block.
package pce_pkg;

	typedef enum logic [1:0] {
		MODE_GRAY   = 2'd0,
		MODE_SEPIA  = 2'd1,
		MODE_INVERT = 2'd2,
		MODE_PASS   = 2'd3
	} mode_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA = 2'd1;

	localparam int unsigned ALPHA_W = 9;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam int unsigned COEF_W  = 10;
	localparam int unsigned FRAC_W  = 10;
	localparam int unsigned SUM_W   = 19;
	localparam int unsigned BLEND_W = 17;

	localparam logic [COEF_W-1:0] C_GRAY_B = 10'd341;
	localparam logic [COEF_W-1:0] C_GRAY_G = 10'd341;
	localparam logic [COEF_W-1:0] C_GRAY_R = 10'd342;

	localparam logic [COEF_W-1:0] C_SR_R = 10'd402;
	localparam logic [COEF_W-1:0] C_SR_G = 10'd787;
	localparam logic [COEF_W-1:0] C_SR_B = 10'd194;
	localparam logic [COEF_W-1:0] C_SG_R = 10'd357;
	localparam logic [COEF_W-1:0] C_SG_G = 10'd702;
	localparam logic [COEF_W-1:0] C_SG_B = 10'd172;
	localparam logic [COEF_W-1:0] C_SB_R = 10'd279;
	localparam logic [COEF_W-1:0] C_SB_G = 10'd547;
	localparam logic [COEF_W-1:0] C_SB_B = 10'd134;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] extra;
	} pix_t;

	typedef struct packed {
		pix_t               pix;
		logic [7:0]         sep_blue;
		logic [7:0]         sep_green;
		logic [7:0]         sep_red;
		logic [7:0]         gray;
		mode_t              mode;
		logic [ALPHA_W-1:0] alpha;
	} mid_t;

	function automatic logic [SUM_W-1:0] mac3(
		input logic [COEF_W-1:0] c0, input logic [7:0] x0,
		input logic [COEF_W-1:0] c1, input logic [7:0] x1,
		input logic [COEF_W-1:0] c2, input logic [7:0] x2
	);
		return SUM_W'(c0) * SUM_W'(x0) + SUM_W'(c1) * SUM_W'(x1)
			+ SUM_W'(c2) * SUM_W'(x2);
	endfunction

	function automatic logic [7:0] clamp_byte(input logic [SUM_W-1:0] s);
		logic [SUM_W-FRAC_W-1:0] sh;
		sh = s[SUM_W-1:FRAC_W];
		return (sh > (SUM_W-FRAC_W)'(8'hFF)) ? 8'hFF : sh[7:0];
	endfunction

endpackage

FILE: hdl/pce_in_if.sv
// Input pixel channel: valid/ready handshake with the source pixel bytes.
interface pce_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_blue;
	logic [7:0] in_green;
	logic [7:0] in_red;
	logic [7:0] in_extra;

	modport source (output valid, in_blue, in_green, in_red, in_extra, input ready);
	modport sink (input valid, in_blue, in_green, in_red, in_extra, output ready);
endinterface

FILE: hdl/pce_out_if.sv
// Output pixel channel: valid/ready handshake with the recolored pixel bytes.
interface pce_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_extra;

	modport source (output valid, out_blue, out_green, out_red, out_extra, input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_extra, output ready);
endinterface

FILE: hdl/pce_matrix.sv
// Color matrix stages: weighted sums, then shift and clamp to sepia and gray bytes.
module pce_matrix import pce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pix_t               in_pix,
	input  mode_t              in_mode,
	input  logic [ALPHA_W-1:0] in_alpha,
	output logic               out_valid,
	input  logic               out_ready,
	output mid_t               out_mid
);

	logic               v_s1;
	pix_t               pix_s1;
	mode_t              mode_s1;
	logic [ALPHA_W-1:0] alpha_s1;
	logic [SUM_W-1:0]   sum_r_s1;
	logic [SUM_W-1:0]   sum_g_s1;
	logic [SUM_W-1:0]   sum_b_s1;
	logic [SUM_W-1:0]   sum_gray_s1;

	logic v_s2;
	mid_t mid_s2;

	logic ready_s1;
	logic ready_s2;

	assign ready_s2 = !v_s2 || out_ready;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) v_s1 <= in_valid;
			if (ready_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			pix_s1      <= in_pix;
			mode_s1     <= in_mode;
			alpha_s1    <= in_alpha;
			sum_r_s1    <= mac3(C_SR_R, in_pix.red, C_SR_G, in_pix.green,
				C_SR_B, in_pix.blue);
			sum_g_s1    <= mac3(C_SG_R, in_pix.red, C_SG_G, in_pix.green,
				C_SG_B, in_pix.blue);
			sum_b_s1    <= mac3(C_SB_R, in_pix.red, C_SB_G, in_pix.green,
				C_SB_B, in_pix.blue);
			sum_gray_s1 <= mac3(C_GRAY_R, in_pix.red, C_GRAY_G, in_pix.green,
				C_GRAY_B, in_pix.blue);
		end
		if (ready_s2 && v_s1) begin
			mid_s2.pix       <= pix_s1;
			mid_s2.sep_red   <= clamp_byte(sum_r_s1);
			mid_s2.sep_green <= clamp_byte(sum_g_s1);
			mid_s2.sep_blue  <= clamp_byte(sum_b_s1);
			mid_s2.gray      <= clamp_byte(sum_gray_s1);
			mid_s2.mode      <= mode_s1;
			mid_s2.alpha     <= alpha_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_mid   = mid_s2;

endmodule

FILE: hdl/pce_blend.sv
// Blend and select stages: alpha mix of sepia with source, then per-mode output register.
module pce_blend import pce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  mid_t in_mid,
	output logic out_valid,
	input  logic out_ready,
	output pix_t out_pix
);

	logic               v_s3;
	pix_t               pix_s3;
	logic [7:0]         gray_s3;
	mode_t              mode_s3;
	logic [BLEND_W-1:0] mix_r_s3;
	logic [BLEND_W-1:0] mix_g_s3;
	logic [BLEND_W-1:0] mix_b_s3;

	logic v_s4;
	pix_t pix_s4;

	logic               ready_s3;
	logic               ready_s4;
	logic [BLEND_W-1:0] w_orig;
	logic [BLEND_W-1:0] w_sep;
	pix_t               sel_pix;

	assign ready_s4 = !v_s4 || out_ready;
	assign ready_s3 = !v_s3 || ready_s4;
	assign in_ready = ready_s3;

	assign w_orig = BLEND_W'(ALPHA_ONE) - BLEND_W'(in_mid.alpha);
	assign w_sep  = BLEND_W'(in_mid.alpha);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ready_s3) v_s3 <= in_valid;
			if (ready_s4) v_s4 <= v_s3;
		end
	end

	always_comb begin
		case (mode_s3)
			MODE_GRAY: begin
				sel_pix = '{blue: gray_s3, green: gray_s3, red: gray_s3, extra: 8'h00};
			end
			MODE_SEPIA: begin
				sel_pix = '{blue: mix_b_s3[15:8], green: mix_g_s3[15:8],
					red: mix_r_s3[15:8], extra: 8'h00};
			end
			MODE_INVERT: begin
				sel_pix = ~pix_s3;
			end
			default: begin
				sel_pix = pix_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			pix_s3   <= in_mid.pix;
			gray_s3  <= in_mid.gray;
			mode_s3  <= in_mid.mode;
			mix_r_s3 <= w_orig * BLEND_W'(in_mid.pix.red) + w_sep * BLEND_W'(in_mid.sep_red);
			mix_g_s3 <= w_orig * BLEND_W'(in_mid.pix.green)
				+ w_sep * BLEND_W'(in_mid.sep_green);
			mix_b_s3 <= w_orig * BLEND_W'(in_mid.pix.blue)
				+ w_sep * BLEND_W'(in_mid.sep_blue);
		end
		if (ready_s4 && v_s3) begin
			pix_s4 <= sel_pix;
		end
	end

	assign out_valid = v_s4;
	assign out_pix   = pix_s4;

endmodule

FILE: hdl/pixel_color_effect.sv
// Top level of the pixel color effect block: config registers, pipeline and channels.
// An accepted input beat moves through stage registers s1 to s4 before its output beat.
// Throughput: one pixel per cycle unless stalled; four stages with per-stage valid bits.
// A stalled output holds its beat; earlier stages keep filling until each holds a pixel.
// Reset clears all valid bits, sets the mode to grayscale and the blend weight to 256.
// Config writes take effect for pixels accepted after the write.
module pixel_color_effect import pce_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pce_in_if.sink                pix_in,
	pce_out_if.source             pix_out
);

	`include "pixel_color_effect_assert.svh"

	mode_t              effect_mode_q;
	logic [ALPHA_W-1:0] blend_alpha_q;
	logic [ALPHA_W-1:0] alpha_sat;
	logic [2:0]         inflight_q;

	pix_t in_pix;
	pix_t out_pix;
	mid_t mid;
	logic mid_valid;
	logic mid_ready;
	logic in_fire;
	logic out_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= MODE_GRAY;
			blend_alpha_q <= ALPHA_ONE;
		end else if (cfg_we) begin
			if (cfg_idx == REG_EFFECT_MODE) effect_mode_q <= mode_t'(cfg_wdata[1:0]);
			if (cfg_idx == REG_BLEND_ALPHA) blend_alpha_q <= cfg_wdata[ALPHA_W-1:0];
		end
	end

	assign alpha_sat = (blend_alpha_q > ALPHA_ONE) ? ALPHA_ONE : blend_alpha_q;

	assign in_pix = '{blue: pix_in.in_blue, green: pix_in.in_green,
		red: pix_in.in_red, extra: pix_in.in_extra};

	pce_matrix u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_pix    (in_pix),
		.in_mode   (effect_mode_q),
		.in_alpha  (alpha_sat),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_mid   (mid)
	);

	pce_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_mid    (mid),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_pix   (out_pix)
	);

	assign pix_out.out_blue  = out_pix.blue;
	assign pix_out.out_green = out_pix.green;
	assign pix_out.out_red   = out_pix.red;
	assign pix_out.out_extra = out_pix.extra;

	assign in_fire  = pix_in.valid && pix_in.ready;
	assign out_fire = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + 3'(in_fire) - 3'(out_fire);
		end
	end

	`PCE_ASSERT_NOW(a_inflight_bound, clk, arst_n, 1'b1, inflight_q <= 3'd4)
	`PCE_ASSERT_NOW(a_empty_no_output, clk, arst_n, inflight_q == 3'd0, !pix_out.valid)
	`PCE_ASSERT_NOW(a_empty_ready, clk, arst_n, inflight_q == 3'd0, pix_in.ready)

endmodule
